### sv/spfa_pkg.sv
// Shared constants for the stack page frame allocator.
`timescale 1ns / 1ps

package spfa_pkg;

   localparam int STACK_DEPTH_DEFAULT = 1024;
   localparam int PAGE_BITS_DEFAULT   = 44;

   // Page numbers after reset, truncated to the page width where used.
   localparam logic [63:0] FIRST_PAGE_RESET = 64'd525312;
   localparam logic [63:0] END_PAGE_RESET   = 64'd557056;

   // Register file: 64-bit registers at byte address 8 * index.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_INDEX_BIT = 3;

   localparam logic REG_FIRST_PAGE = 1'b0;
   localparam logic REG_END_PAGE   = 1'b1;

   // Request opcode, carried in req_tuser.
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   // Response status, carried in rsp_tuser.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_OOM     = 2'd1,
      STATUS_BADFREE = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

endpackage

### sv/stack_page_frame_allocator.sv
// Top level of the stack page frame allocator: sequencer, recycled stack memory, result register.
`timescale 1ns / 1ps

// Page frame allocator. Each request beat carries an opcode in req_tuser (0 allocate,
// 1 free) and a page number in req_tdata; each request yields exactly one response beat
// with the page in rsp_tdata and the status in rsp_tuser (0 ok, 1 out of memory,
// 2 invalid or double free, 3 recycled stack full). Allocate pops the most recently
// freed page, or hands out the next fresh page until end_page is reached. Free rejects
// a page at or above the fresh counter or one already on the stack, else pushes it
// unless the stack is full. One request is worked on at a time, through a single stack
// memory with one read port and a registered read. Allocate registers its response
// straight from the EXEC state with an empty stack, and after reading the top entry
// on a pop. Free registers it straight from the EXEC state when rejected by the range
// check or when the stack is empty; otherwise it reads the stack one entry per cycle
// from the bottom until a match or the top, then registers it. A full response register
// holds the finished response back until rsp_tready drains it. The next request is
// taken the cycle after the response is registered, even while that response still
// waits on rsp_tready. The stack needs no clearing pass after reset. Writing first_page
// restarts the fresh counter there and empties the stack; writing end_page only moves
// the bound.

module stack_page_frame_allocator #(
   parameter int STACK_DEPTH = spfa_pkg::STACK_DEPTH_DEFAULT,
   parameter int PAGE_BITS   = spfa_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((PAGE_BITS+7)/8)*8-1:0]     req_tdata,   // page_number
   input  logic                               req_tuser,   // opcode
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((PAGE_BITS+7)/8)*8-1:0]     rsp_tdata,   // page_number_out
   output logic [1:0]                         rsp_tuser,   // status
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [spfa_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [63:0]                        csr_pwdata,
   output logic [63:0]                        csr_prdata,
   output logic                               csr_pready
);
   import spfa_pkg::*;

   localparam int TDATA_BITS = ((PAGE_BITS + 7) / 8) * 8;
   localparam int AW         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW         = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_POP  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic                 op_ff, op_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [PAGE_BITS-1:0] next_fresh_ff, next_fresh_in;
   logic [AW-1:0]        scan_addr_ff, scan_addr_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PAGE_BITS-1:0] rsp_page_ff, rsp_page_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic [PAGE_BITS-1:0] stack_mem [STACK_DEPTH];
   logic [PAGE_BITS-1:0] rd_data_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;

   logic [CW-1:0]        cnt_m1;
   logic                 slot_free;
   logic                 fin_go;
   logic [PAGE_BITS-1:0] fin_page;
   logic [1:0]           fin_status;

   logic [PAGE_BITS-1:0] end_page;
   logic                 cfg_load;
   logic [PAGE_BITS-1:0] cfg_load_page;

   spfa_csr #(
      .PAGE_BITS (PAGE_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .end_page    (end_page),
      .load        (cfg_load),
      .load_page   (cfg_load_page)
   );

   assign cnt_m1     = count_ff - CW'(1);
   // The response register can take a new beat when empty or being drained.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer: one request at a time; state updates commit with the response.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      count_in      = count_ff;
      next_fresh_in = next_fresh_ff;
      scan_addr_in  = scan_addr_ff;
      hit_in        = hit_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_addr_ff;
      wr_en         = 1'b0;
      fin_go        = 1'b0;
      fin_page      = '0;
      fin_status    = STATUS_OK;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               page_in  = req_tdata[PAGE_BITS-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_FREE) begin
               if (page_ff >= next_fresh_ff) begin
                  // never handed out
                  if (slot_free) begin
                     fin_go     = 1'b1;
                     fin_status = STATUS_BADFREE;
                     state_in   = ST_IDLE;
                  end
               end else if (count_ff == '0) begin
                  // empty stack: nothing to search, push at the bottom
                  if (slot_free) begin
                     fin_go   = 1'b1;
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                     state_in = ST_IDLE;
                  end
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = '0;
                  scan_addr_in = '0;
                  hit_in       = 1'b0;
                  state_in     = ST_SCAN;
               end
            end else begin
               if (count_ff != '0) begin
                  // fetch the top of the stack
                  rd_en    = 1'b1;
                  rd_addr  = cnt_m1[AW-1:0];
                  state_in = ST_POP;
               end else if (slot_free) begin
                  fin_go   = 1'b1;
                  state_in = ST_IDLE;
                  if (next_fresh_ff >= end_page) begin
                     fin_status = STATUS_OOM;
                  end else begin
                     fin_page      = next_fresh_ff;
                     next_fresh_in = next_fresh_ff + PAGE_BITS'(1);
                  end
               end
            end
         end
         ST_POP: begin
            // read data holds until the response register frees up
            if (slot_free) begin
               fin_go   = 1'b1;
               fin_page = rd_data_ff;
               count_in = cnt_m1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (rd_data_ff == page_ff) begin
               hit_in   = 1'b1;
               state_in = ST_FIN;
            end else if (scan_addr_ff == cnt_m1[AW-1:0]) begin
               state_in = ST_FIN;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = scan_addr_ff + AW'(1);
               scan_addr_in = scan_addr_ff + AW'(1);
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               fin_go   = 1'b1;
               state_in = ST_IDLE;
               if (hit_ff) begin
                  fin_status = STATUS_BADFREE;
               end else if (count_ff == CW'(STACK_DEPTH)) begin
                  fin_status = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // first_page write restarts the allocator; user sends writes only while idle (unenforced).
      if (cfg_load) begin
         next_fresh_in = cfg_load_page;
         count_in      = '0;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      if (fin_go) begin
         rsp_valid_in  = 1'b1;
         rsp_page_in   = fin_page;
         rsp_status_in = fin_status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         next_fresh_ff <= FIRST_PAGE_RESET[PAGE_BITS-1:0];
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_fresh_ff <= next_fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      page_ff       <= page_in;
      scan_addr_ff  <= scan_addr_in;
      hit_ff        <= hit_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Recycled stack memory: push at the current count, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[count_ff[AW-1:0]] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_page_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

### sv/spfa_csr.sv
// Configuration registers and their APB-style access port.
`timescale 1ns / 1ps

module spfa_csr #(
   parameter int PAGE_BITS = spfa_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [spfa_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [63:0]                        csr_pwdata,
   output logic [63:0]                        csr_prdata,
   output logic                               csr_pready,
   output logic [PAGE_BITS-1:0]               end_page,
   output logic                               load,
   output logic [PAGE_BITS-1:0]               load_page
);
   import spfa_pkg::*;

   logic [PAGE_BITS-1:0] first_page_ff, first_page_in;
   logic [PAGE_BITS-1:0] end_page_ff, end_page_in;
   logic                 wr_go;
   logic                 reg_index;

   assign csr_pready = 1'b1;
   assign wr_go      = csr_psel & csr_penable & csr_pwrite;
   assign reg_index  = csr_paddr[CSR_INDEX_BIT];

   always_comb begin
      first_page_in = first_page_ff;
      end_page_in   = end_page_ff;
      load          = 1'b0;
      if (wr_go) begin
         case (reg_index)
            REG_FIRST_PAGE: begin
               first_page_in = csr_pwdata[PAGE_BITS-1:0];
               load          = 1'b1;
            end
            REG_END_PAGE: begin
               end_page_in = csr_pwdata[PAGE_BITS-1:0];
            end
            default: begin
               load = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FIRST_PAGE: csr_prdata = 64'(first_page_ff);
         REG_END_PAGE:   csr_prdata = 64'(end_page_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= FIRST_PAGE_RESET[PAGE_BITS-1:0];
         end_page_ff   <= END_PAGE_RESET[PAGE_BITS-1:0];
      end else begin
         first_page_ff <= first_page_in;
         end_page_ff   <= end_page_in;
      end
   end

   assign end_page  = end_page_ff;
   assign load_page = csr_pwdata[PAGE_BITS-1:0];

endmodule

### tb/stack_page_frame_allocator_tb.sv
// Self-checking testbench for the stack page frame allocator: directed plan, full stack, traffic.
`timescale 1ns / 1ps

module stack_page_frame_allocator_tb;

   import spfa_pkg::*;

   localparam int PAGE_W      = PAGE_BITS_DEFAULT;
   localparam int DATA_W      = ((PAGE_W + 7) / 8) * 8;
   localparam int STACK_DEPTH = STACK_DEPTH_DEFAULT;

   typedef logic [PAGE_W-1:0] page_type;

   localparam page_type MAX_PAGE  = '1;
   localparam page_type FILL_BASE = page_type'(64'h100);

   // Worst case per beat: a free that walks the whole stack, plus long
   // stall runs on either side. Take it four times over for every beat.
   localparam int  BEAT_CEILING = 2700;
   localparam longint unsigned CYCLE_LIMIT = 64'(BEAT_CEILING) * (STACK_DEPTH + 64) * 4;

   typedef struct {
      page_type   page;
      status_type status;
   } frame_result_type;

   // One row of the directed plan: either a request or a register write.
   typedef struct {
      bit               is_write;
      logic             reg_idx;
      opcode_type       op;
      page_type         page;      // page to free, or register value on a write
      bit               pinned;    // expected result typed into the plan
      frame_result_type result;
   } plan_row_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata   = '0;   // [43:0] page_number, [47:44] zero fill
   logic              req_tuser   = 1'b0; // [0] opcode
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;          // [43:0] page_number_out, [47:44] zero fill
   logic [1:0]        rsp_tuser;          // [1:0] status
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [63:0]              csr_pwdata  = '0;
   logic [63:0]              csr_prdata;
   logic                     csr_pready;

   stack_page_frame_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Allocator shadow state, updated at each accepted beat or CSR write
   // ---------------------------------------------------------------------
   page_type first_page_reg = page_type'(FIRST_PAGE_RESET);
   page_type end_page_reg   = page_type'(END_PAGE_RESET);
   page_type next_fresh_pg  = page_type'(FIRST_PAGE_RESET);
   page_type recycled_q[$];       // top of the stack at the back
   page_type handed_out_q[$];     // pages allocated and not yet freed

   frame_result_type awaited_frames[$];

   // Result typed into the plan for the beat now on the request bus
   bit               pin_active = 1'b0;
   frame_result_type pin_result;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   int unsigned n_allocs   = 0;
   int unsigned n_frees    = 0;
   int unsigned n_checked  = 0;
   int unsigned n_fail     = 0;
   int unsigned status_seen[4] = '{default: 0};
   longint unsigned cycle_count = 0;

   plan_row_type directed_plan[$];

   function automatic page_type rand_page();
      return page_type'({$urandom(), $urandom()});
   endfunction

   // Work out the response to one request and advance the shadow state.
   task automatic predict_frame(input opcode_type op, input page_type pg,
                                output frame_result_type res);
      bit on_stack;
      int slot;
      on_stack   = 1'b0;
      slot       = -1;
      res.page   = '0;
      res.status = STATUS_OK;
      if (op == OP_ALLOC) begin
         if (recycled_q.size() != 0) begin
            res.page = recycled_q.pop_back();
            handed_out_q.push_back(res.page);
         end else if (next_fresh_pg >= end_page_reg) begin
            res.status = STATUS_OOM;
         end else begin
            res.page = next_fresh_pg;
            handed_out_q.push_back(next_fresh_pg);
            next_fresh_pg = next_fresh_pg + 1'b1;
         end
      end else begin
         foreach (recycled_q[i]) if (recycled_q[i] == pg) on_stack = 1'b1;
         // the range and duplicate check wins over the full check
         if (pg >= next_fresh_pg || on_stack) begin
            res.status = STATUS_BADFREE;
         end else if (recycled_q.size() >= STACK_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            recycled_q.push_back(pg);
            foreach (handed_out_q[i]) if (handed_out_q[i] == pg) slot = i;
            if (slot >= 0) handed_out_q.delete(slot);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Bus watch: apply CSR writes, predict accepted requests, check responses
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : bus_watch
      frame_result_type want;
      frame_result_type got;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CSR_INDEX_BIT] == REG_FIRST_PAGE) begin
               // a new first page restarts the allocator from scratch
               first_page_reg = page_type'(csr_pwdata);
               next_fresh_pg  = first_page_reg;
               recycled_q.delete();
               handed_out_q.delete();
            end else begin
               end_page_reg = page_type'(csr_pwdata);
            end
         end

         if (req_tvalid && req_tready) begin
            predict_frame(opcode_type'(req_tuser), req_tdata[PAGE_W-1:0], want);
            if (pin_active) want = pin_result;
            awaited_frames.push_back(want);
            if (req_tuser == OP_ALLOC) n_allocs++;
            else n_frees++;
         end

         if (rsp_tvalid && rsp_tready) begin
            got.page = rsp_tdata[PAGE_W-1:0];
            if (awaited_frames.size() == 0) begin
               $error("response beat with nothing outstanding: page %0h status %0d",
                      got.page, rsp_tuser);
               n_fail++;
            end else begin
               want = awaited_frames.pop_front();
               if (got.page !== want.page) begin
                  $error("page_number_out: expected %0h, got %0h", want.page, got.page);
                  n_fail++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  n_fail++;
               end
               if (!$isunknown(rsp_tuser)) status_seen[rsp_tuser]++;
               n_checked++;
            end
         end
      end
   end

   // Receiver: stall at random, or never in the quiet phases.
   always @(negedge clock) begin
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a hung block ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited_frames.size());
         $display("[stack_page_frame_allocator] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers; every call starts and ends at a falling edge
   // ---------------------------------------------------------------------

   // Send one request beat. Drop any CSR burst first, idle at random, then
   // hold the beat until the block takes it.
   task automatic push_request(input opcode_type op, input page_type pg,
                               input bit pinned = 1'b0, input page_type pin_pg = '0,
                               input status_type pin_st = STATUS_OK);
      if (csr_psel) begin
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
      end
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      pin_active      = pinned;
      pin_result.page   = pin_pg;
      pin_result.status = pin_st;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= DATA_W'(pg);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Lower the request bus and wait until every response is back.
   task automatic drain();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (awaited_frames.size() != 0) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; psel stays up so writes can go back to back.
   task automatic csr_write(input logic idx, input page_type value);
      logic [CSR_ADDR_BITS-1:0] addr;
      addr                = '0;
      addr[CSR_INDEX_BIT] = idx;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= 64'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   // Mostly legal traffic: allocates and frees of pages in hand, with double
   // frees, frees past the fresh counter, frees below first_page and noise.
   task automatic send_random_request();
      int unsigned roll;
      page_type    pg;
      opcode_type  op;
      roll = $urandom_range(99);
      pg   = rand_page();
      op   = OP_FREE;
      if (roll < 42) begin
         op = OP_ALLOC;
      end else if (roll < 72 && handed_out_q.size() != 0) begin
         pg = handed_out_q[$urandom_range(handed_out_q.size() - 1)];
      end else if (roll < 82 && recycled_q.size() != 0) begin
         pg = recycled_q[$urandom_range(recycled_q.size() - 1)];
      end else if (roll < 90) begin
         pg = next_fresh_pg + page_type'($urandom_range(3));
      end else if (roll < 95 && first_page_reg != 0) begin
         pg = rand_page() % first_page_reg;
      end
      push_request(op, pg);
   endtask

   // One traffic phase: set both bounds, run half the beats, move end_page
   // with the state kept, run the rest.
   task automatic run_traffic(input page_type first, input page_type end_a,
                              input page_type end_b,
                              input int unsigned s_pct, input int unsigned r_pct,
                              input int unsigned beats);
      drain();
      csr_write(REG_FIRST_PAGE, first);
      csr_write(REG_END_PAGE, end_a);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (beats / 2) send_random_request();
      drain();
      csr_write(REG_END_PAGE, end_b);
      repeat (beats - beats / 2) send_random_request();
      drain();
   endtask

   function automatic void plan_item(input opcode_type op, input page_type pg);
      plan_row_type r;
      r = '{is_write: 1'b0, reg_idx: 1'b0, op: op, page: pg, pinned: 1'b0,
            result: '{page: '0, status: STATUS_OK}};
      directed_plan.push_back(r);
   endfunction

   function automatic void plan_known(input opcode_type op, input page_type pg,
                                      input page_type exp_pg, input status_type exp_st);
      plan_row_type r;
      r = '{is_write: 1'b0, reg_idx: 1'b0, op: op, page: pg, pinned: 1'b1,
            result: '{page: exp_pg, status: exp_st}};
      directed_plan.push_back(r);
   endfunction

   function automatic void plan_write(input logic idx, input page_type value);
      plan_row_type r;
      r = '{is_write: 1'b1, reg_idx: idx, op: OP_ALLOC, page: value, pinned: 1'b0,
            result: '{page: '0, status: STATUS_OK}};
      directed_plan.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      page_type first_c;

      // Directed plan, starting from the reset bounds 525312 .. 557056.
      // Most allocate operands carry random page bits, which the block ignores.
      plan_known(OP_ALLOC, rand_page(), page_type'(525312), STATUS_OK);
      plan_known(OP_ALLOC, rand_page(), page_type'(525313), STATUS_OK);
      plan_known(OP_FREE,  page_type'(525312), '0, STATUS_OK);
      plan_known(OP_FREE,  page_type'(525312), '0, STATUS_BADFREE);   // double free
      plan_known(OP_FREE,  page_type'(525314), '0, STATUS_BADFREE);   // never handed out
      plan_known(OP_FREE,  MAX_PAGE,           '0, STATUS_BADFREE);
      plan_known(OP_FREE,  page_type'(5),      '0, STATUS_OK);        // below first_page
      plan_known(OP_ALLOC, rand_page(), page_type'(5), STATUS_OK);    // last in, first out
      plan_known(OP_ALLOC, rand_page(), page_type'(525312), STATUS_OK);
      plan_item (OP_ALLOC, rand_page());
      // pull the bound down onto the fresh counter: state stays
      plan_write(REG_END_PAGE, page_type'(525315));
      plan_known(OP_ALLOC, rand_page(), '0, STATUS_OOM);
      plan_item (OP_FREE,  page_type'(525313));
      plan_item (OP_ALLOC, rand_page());
      plan_known(OP_ALLOC, rand_page(), '0, STATUS_OOM);
      // all-zero bounds
      plan_write(REG_FIRST_PAGE, '0);
      plan_write(REG_END_PAGE, '0);
      plan_known(OP_ALLOC, '0, '0, STATUS_OOM);
      plan_known(OP_FREE,  '0, '0, STATUS_BADFREE);
      plan_write(REG_END_PAGE, MAX_PAGE);
      plan_known(OP_ALLOC, MAX_PAGE, '0, STATUS_OK);
      plan_item (OP_FREE,  '0);
      // top of the page space: one page fits below end_page
      plan_write(REG_FIRST_PAGE, MAX_PAGE - 1'b1);
      plan_known(OP_ALLOC, rand_page(), MAX_PAGE - 1'b1, STATUS_OK);
      plan_known(OP_ALLOC, rand_page(), '0, STATUS_OOM);
      plan_known(OP_FREE,  MAX_PAGE, '0, STATUS_BADFREE);
      plan_item (OP_FREE,  MAX_PAGE - 1'b1);
      plan_known(OP_ALLOC, rand_page(), MAX_PAGE - 1'b1, STATUS_OK);

      // hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write) begin
            drain();
            csr_write(directed_plan[i].reg_idx, directed_plan[i].page);
         end else begin
            push_request(directed_plan[i].op, directed_plan[i].page,
                         directed_plan[i].pinned, directed_plan[i].result.page,
                         directed_plan[i].result.status);
         end
      end

      // Fill the recycled stack to the brim with pages below first_page, then push one more.
      drain();
      csr_write(REG_FIRST_PAGE, FILL_BASE + page_type'(STACK_DEPTH + 1));
      csr_write(REG_END_PAGE, FILL_BASE + page_type'(STACK_DEPTH + 8));
      for (int i = 0; i < STACK_DEPTH; i++) push_request(OP_FREE, FILL_BASE + page_type'(i));
      push_request(OP_FREE, FILL_BASE + page_type'(STACK_DEPTH), 1'b1, '0, STATUS_FULL);
      // duplicate check comes before the full check
      push_request(OP_FREE, FILL_BASE, 1'b1, '0, STATUS_BADFREE);
      push_request(OP_ALLOC, rand_page(), 1'b1,
                   FILL_BASE + page_type'(STACK_DEPTH - 1), STATUS_OK);
      push_request(OP_FREE, FILL_BASE + page_type'(STACK_DEPTH));

      // Traffic phases: no idling, sender idle, receiver stalling, both.
      first_c = rand_page() >> 2;
      run_traffic(first_c, first_c + page_type'(48), first_c + page_type'(96), 0, 0, 145);
      run_traffic(MAX_PAGE - page_type'(40), MAX_PAGE, MAX_PAGE - page_type'(30), 51, 0, 145);
      first_c = rand_page() >> 1;
      run_traffic(first_c, first_c + page_type'($urandom_range(1, 64)), '0, 0, 51, 145);
      run_traffic('0, MAX_PAGE, page_type'(32), 15, 15, 145);

      // let any stray response show up before the verdict
      drain();
      repeat (STACK_DEPTH + 8) @(posedge clock);

      $display("Ran %0d requests (%0d allocates, %0d frees): directed plan, full stack, %s",
               n_allocs + n_frees, n_allocs, n_frees, "four traffic phases.");
      $display("Checked %0d responses; ok/oom/bad free/full = %0d/%0d/%0d/%0d; %0d mismatches.",
               n_checked, status_seen[STATUS_OK], status_seen[STATUS_OOM],
               status_seen[STATUS_BADFREE], status_seen[STATUS_FULL], n_fail);
      if (n_fail == 0) begin
         $display("[stack_page_frame_allocator] OK");
      end else begin
         $display("[stack_page_frame_allocator] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
sv/spfa_pkg.sv
sv/spfa_csr.sv
sv/stack_page_frame_allocator.sv
tb/stack_page_frame_allocator_tb.sv
